>>> sv/bbtm_pkg.sv
// ----------------------------------------------------------------------------
// bbtm_pkg
// Shared types, constants and the SM83 opcode length table for the
// backward branch target marker.
// ----------------------------------------------------------------------------
package bbtm_pkg;

  // scanned window length, 16 to 256 bytes
  localparam int WINDOW_BYTES = 256;
  localparam int OFFSET_W     = 8;
  localparam int POS_W        = 9;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_FEED  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // relative jump opcodes
  localparam logic [7:0] OP_JR    = 8'h18;
  localparam logic [7:0] OP_JR_NZ = 8'h20;
  localparam logic [7:0] OP_JR_Z  = 8'h28;
  localparam logic [7:0] OP_JR_NC = 8'h30;
  localparam logic [7:0] OP_JR_C  = 8'h38;

  typedef struct packed {
    logic                mark_valid;
    logic [OFFSET_W-1:0] mark_offset;
    logic                done_nxt;
  } walk_res_t;

  // instruction length in bytes, cb prefix counts as two
  function automatic logic [1:0] op_len(input logic [7:0] op);
    logic [1:0] len;
    case (op) inside
      8'h01, 8'h08, 8'h11, 8'h21, 8'h31, 8'hC2, 8'hC3, 8'hC4, 8'hCA,
      8'hCC, 8'hCD, 8'hD2, 8'hD4, 8'hDA, 8'hDC, 8'hEA, 8'hFA:
        len = 2'd3;
      8'h06, 8'h0E, 8'h10, 8'h16, 8'h18, 8'h1E, 8'h20, 8'h26, 8'h28,
      8'h2E, 8'h30, 8'h36, 8'h38, 8'h3E, 8'hC6, 8'hCB, 8'hCE, 8'hD6,
      8'hDE, 8'hE0, 8'hE6, 8'hE8, 8'hEE, 8'hF0, 8'hF6, 8'hF8, 8'hFE:
        len = 2'd2;
      default:
        len = 2'd1;
    endcase
    return len;
  endfunction

  function automatic logic is_rel_jump(input logic [7:0] op);
    return (op == OP_JR) || (op == OP_JR_NZ) || (op == OP_JR_Z) ||
           (op == OP_JR_NC) || (op == OP_JR_C);
  endfunction

endpackage

>>> sv/bbtm_walk.sv
// ----------------------------------------------------------------------------
// bbtm_walk
// Instruction walk over the fed code bytes: tracks instruction starts,
// pending jump displacements and the end of the scan, and resolves
// backward branch targets.
// ----------------------------------------------------------------------------
module bbtm_walk
  import bbtm_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       feed_en,
  input  logic       clear,
  input  logic [7:0] byte_value,
  output walk_res_t  res
);

  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [POS_W-1:0]    nis_r, nis_nxt;
  logic                await_r, await_nxt;
  logic [OFFSET_W-1:0] jmp_r, jmp_nxt;
  logic                done_r, done_nxt;

  logic signed [10:0]  tgt;
  logic                tgt_ok;
  logic                mark_valid;
  logic [OFFSET_W-1:0] mark_offset;

  // target = jump offset + 2 + signed displacement
  assign tgt    = $signed({3'b000, jmp_r}) + $signed(11'd2)
                + $signed({{3{byte_value[7]}}, byte_value});
  assign tgt_ok = !tgt[10] && (tgt[9:0] < {2'b00, jmp_r});

  always_comb begin
    pos_nxt     = pos_r;
    nis_nxt     = nis_r;
    await_nxt   = await_r;
    jmp_nxt     = jmp_r;
    done_nxt    = done_r;
    mark_valid  = 1'b0;
    mark_offset = '0;
    if (clear) begin
      pos_nxt   = '0;
      nis_nxt   = '0;
      await_nxt = 1'b0;
      jmp_nxt   = '0;
      done_nxt  = 1'b0;
    end else if (feed_en && !done_r) begin
      if (await_r) begin
        if (tgt_ok) begin
          mark_valid  = 1'b1;
          mark_offset = tgt[OFFSET_W-1:0];
        end
        await_nxt = 1'b0;
      end else if (pos_r == nis_r) begin
        nis_nxt = pos_r + POS_W'(op_len(byte_value));
        if (is_rel_jump(byte_value)) begin
          await_nxt = 1'b1;
          jmp_nxt   = pos_r[OFFSET_W-1:0];
        end
      end
      pos_nxt = pos_r + POS_W'(1);
      if (!await_nxt && (nis_nxt >= POS_W'(WINDOW_BYTES))) begin
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      nis_r   <= '0;
      await_r <= 1'b0;
      jmp_r   <= '0;
      done_r  <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      nis_r   <= nis_nxt;
      await_r <= await_nxt;
      jmp_r   <= jmp_nxt;
      done_r  <= done_nxt;
    end
  end

  assign res.mark_valid  = mark_valid;
  assign res.mark_offset = mark_offset;
  assign res.done_nxt    = done_nxt;

endmodule

>>> sv/backward_branch_target_marker.sv
// ----------------------------------------------------------------------------
// backward_branch_target_marker
// SM83 length predecoder that marks backward relative branch targets.
// ----------------------------------------------------------------------------
// One command is taken per clock while in_ready is high; its result is
// registered, and with out_ready held high the block sustains one item
// every cycle. Each item is handled by a single pass through the opcode
// length lookup and the 11-bit target add and compare. While a result
// waits in the output register the input is held off, and the next item
// is taken in the same cycle that the waiting result leaves. The 256
// target marks live in flip-flops, so a start command clears them in the
// same cycle and a query reads the marks written by every earlier transfer.
module backward_branch_target_marker
  import bbtm_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_cmd,
  input  logic [7:0]          in_byte_value,
  input  logic [OFFSET_W-1:0] in_query_offset,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_query_marked,
  output logic                out_mark_valid,
  output logic [OFFSET_W-1:0] out_mark_offset,
  output logic                out_scan_done
);

  logic                     accept;
  logic                     feed_en;
  logic                     clear;
  walk_res_t                walk_res;
  logic [2**OFFSET_W-1:0]   mark_bits_r;

  logic                     out_valid_r;
  logic                     query_marked_r;
  logic                     mark_valid_r;
  logic [OFFSET_W-1:0]      mark_offset_r;
  logic                     scan_done_r;

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;
  assign feed_en  = accept && (in_cmd == CMD_FEED);
  assign clear    = accept && (in_cmd == CMD_START);

  bbtm_walk u_walk (
    .clk        (clk),
    .rst_n      (rst_n),
    .feed_en    (feed_en),
    .clear      (clear),
    .byte_value (in_byte_value),
    .res        (walk_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      mark_bits_r <= '0;
    end else if (walk_res.mark_valid) begin
      mark_bits_r[walk_res.mark_offset] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      query_marked_r <= (in_cmd == CMD_QUERY) && mark_bits_r[in_query_offset];
      mark_valid_r   <= walk_res.mark_valid;
      mark_offset_r  <= walk_res.mark_offset;
      scan_done_r    <= walk_res.done_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_query_marked = query_marked_r;
  assign out_mark_valid   = mark_valid_r;
  assign out_mark_offset  = mark_offset_r;
  assign out_scan_done    = scan_done_r;

endmodule

>>> sv/bbtm_checker.sv
// ----------------------------------------------------------------------------
// bbtm_checker
// Port-level checks for the backward branch target marker.
// ----------------------------------------------------------------------------
module bbtm_checker
  import bbtm_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic [1:0]          in_cmd,
  input logic                out_valid,
  input logic                out_ready,
  input logic                out_query_marked,
  input logic                out_mark_valid,
  input logic [OFFSET_W-1:0] out_mark_offset,
  input logic                out_scan_done
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_query_marked) &&
      $stable(out_mark_valid) && $stable(out_mark_offset) && $stable(out_scan_done))
    else $error("stalled result changed");

  // a query never marks and a fed byte never reports a query hit
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mark_valid |-> !out_query_marked)
    else $error("mark and query hit in one result");

  a_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_mark_valid |-> out_mark_offset == '0)
    else $error("mark offset set without a mark");

  // a start transfer yields an all-zero result in the next cycle
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_cmd == CMD_START) |=>
      out_valid && !out_scan_done && !out_mark_valid && !out_query_marked)
    else $error("start result not cleared");

endmodule

bind backward_branch_target_marker bbtm_checker u_bbtm_checker (.*);
